// ===== hw/rtl/cyc2us_pkg.sv =====
`timescale 1ns / 1ps
package cyc2us_pkg;

   localparam int unsigned WORD_W = 64;
   localparam int unsigned FREQ_W = 37;
   localparam int unsigned RATE_W = 21;
   localparam int unsigned USEC_W = 20;
   localparam int unsigned LO_PROD_W = 32 + USEC_W;
   localparam int unsigned PART_PROD_W = FREQ_W + USEC_W;
   localparam int unsigned CHAIN_LEN = WORD_W;

   localparam logic [USEC_W-1:0] USEC_PER_SEC = USEC_W'(1000000);
   localparam logic [RATE_W-1:0] DEFAULT_TICK_HZ = RATE_W'(1000);

   typedef enum logic [1:0] {
      CSR_CYCLE_FREQ_HZ = 2'd0,
      CSR_CYCLE_BASE    = 2'd1,
      CSR_TICK_RATE_HZ  = 2'd2,
      CSR_UNUSED        = 2'd3
   } csr_index_type;

   // one beat moving down a divider chain
   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] quo;   // dividend bits shifting out, quotient bits shifting in
      logic [FREQ_W-1:0] rem;
      logic [WORD_W-1:0] side;  // passenger word
   } stage_type;

endpackage

// ===== hw/rtl/cyc2us_div_cell.sv =====
`timescale 1ns / 1ps
module cyc2us_div_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [cyc2us_pkg::FREQ_W-1:0] divisor,
   input  cyc2us_pkg::stage_type        stage_in,
   output cyc2us_pkg::stage_type        stage_out
);
   import cyc2us_pkg::*;

   logic              valid_ff;
   logic [WORD_W-1:0] quo_ff;
   logic [FREQ_W-1:0] rem_ff;
   logic [WORD_W-1:0] side_ff;

   logic [FREQ_W:0]   trial;
   logic              fits;
   logic [FREQ_W:0]   diff;
   logic [FREQ_W-1:0] rem_in;
   logic [WORD_W-1:0] quo_in;

   // one restoring step: bring down a bit, subtract if it fits
   always_comb begin
      trial  = {stage_in.rem, stage_in.quo[WORD_W-1]};
      fits   = trial >= {1'b0, divisor};
      diff   = trial - {1'b0, divisor};
      rem_in = fits ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
      quo_in = {stage_in.quo[WORD_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage_in.valid;
      end
      if (advance) begin
         quo_ff  <= quo_in;
         rem_ff  <= rem_in;
         side_ff <= stage_in.side;
      end
   end

   assign stage_out = '{valid: valid_ff, quo: quo_ff, rem: rem_ff, side: side_ff};

endmodule

// ===== hw/rtl/cyc2us_div_chain.sv =====
`timescale 1ns / 1ps
module cyc2us_div_chain (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [cyc2us_pkg::FREQ_W-1:0] divisor,
   input  cyc2us_pkg::stage_type        chain_in,
   output cyc2us_pkg::stage_type        chain_out
);
   import cyc2us_pkg::*;

   stage_type link [0:CHAIN_LEN];

   assign link[0] = chain_in;

   for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_cell
      cyc2us_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .divisor   (divisor),
         .stage_in  (link[i]),
         .stage_out (link[i+1])
      );
   end

   assign chain_out = link[CHAIN_LEN];

endmodule

// ===== hw/rtl/cycle_count_to_microseconds_core.sv =====
`timescale 1ns / 1ps
// pipeline: 133 register stages from req beat to rsp_valid (2 front stages,
//   64-cell divider, 2 scaling stages, 64-cell divider, output register)
// throughput: one beat per cycle while not stalled; one quotient bit per divider cell
// reset: synchronous active-high reset clears all valid bits and sets the three
//   csr registers to zero (tick path at 1000 Hz)
module cycle_count_to_microseconds_core (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cyc2us_pkg::WORD_W-1:0] req_cycle_now,
   input  logic [cyc2us_pkg::WORD_W-1:0] req_tick_now,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [cyc2us_pkg::WORD_W-1:0] rsp_time_us,
   // csr write port
   input  logic                          csr_write_en,
   input  cyc2us_pkg::csr_index_type     csr_index,
   input  logic [cyc2us_pkg::WORD_W-1:0] csr_wdata
);
   import cyc2us_pkg::*;

   // csr registers
   logic [FREQ_W-1:0] freq_ff;
   logic [WORD_W-1:0] base_ff;
   logic [RATE_W-1:0] rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff <= '0;
         base_ff <= '0;
         rate_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_CYCLE_FREQ_HZ: freq_ff <= csr_wdata[FREQ_W-1:0];
            CSR_CYCLE_BASE:    base_ff <= csr_wdata;
            CSR_TICK_RATE_HZ:  rate_ff <= csr_wdata[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   // cycle path when a frequency is calibrated, otherwise tick path
   logic              cycle_mode;
   logic [FREQ_W-1:0] div2_divisor;

   assign cycle_mode   = freq_ff != '0;
   assign div2_divisor = cycle_mode ? freq_ff
                       : FREQ_W'(rate_ff != '0 ? rate_ff : DEFAULT_TICK_HZ);

   // whole pipeline moves together; held only when a result sits unread
   logic advance;
   logic out_valid_ff;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // front stage 0: base subtract and tick partial products
   logic                 s0_valid_ff;
   logic [WORD_W-1:0]    s0_delta_ff;
   logic [LO_PROD_W-1:0] s0_tick_lo_ff;
   logic [31:0]          s0_tick_hi_ff;
   logic [31:0]          tick_hi_in;

   assign tick_hi_in = req_tick_now[63:32] * 32'(USEC_PER_SEC);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
      end
      if (advance) begin
         s0_delta_ff   <= req_cycle_now - base_ff;
         s0_tick_lo_ff <= LO_PROD_W'(req_tick_now[31:0]) * LO_PROD_W'(USEC_PER_SEC);
         s0_tick_hi_ff <= tick_hi_in;
      end
   end

   // front stage 1: tick product modulo 2^64
   logic              s1_valid_ff;
   logic [WORD_W-1:0] s1_delta_ff;
   logic [WORD_W-1:0] s1_tick_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s0_valid_ff;
      end
      if (advance) begin
         s1_delta_ff     <= s0_delta_ff;
         s1_tick_prod_ff <= WORD_W'(s0_tick_lo_ff) + {s0_tick_hi_ff, 32'd0};
      end
   end

   // first divider: delta / freq, tick product rides along
   stage_type div1_in;
   stage_type div1_out;

   assign div1_in = '{valid: s1_valid_ff,
                      quo:   cycle_mode ? s1_delta_ff : '0,
                      rem:   '0,
                      side:  s1_tick_prod_ff};

   cyc2us_div_chain u_div1 (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .divisor   (freq_ff),
      .chain_in  (div1_in),
      .chain_out (div1_out)
   );

   // scale stage 0: remainder and whole-units partial products
   logic                   m0_valid_ff;
   logic [PART_PROD_W-1:0] m0_part_prod_ff;
   logic [LO_PROD_W-1:0]   m0_whole_lo_ff;
   logic [31:0]            m0_whole_hi_ff;
   logic [WORD_W-1:0]      m0_tick_prod_ff;
   logic [31:0]            whole_hi_in;

   assign whole_hi_in = div1_out.quo[63:32] * 32'(USEC_PER_SEC);

   always_ff @(posedge clock) begin
      if (reset) begin
         m0_valid_ff <= 1'b0;
      end else if (advance) begin
         m0_valid_ff <= div1_out.valid;
      end
      if (advance) begin
         m0_part_prod_ff <= PART_PROD_W'(div1_out.rem) * PART_PROD_W'(USEC_PER_SEC);
         m0_whole_lo_ff  <= LO_PROD_W'(div1_out.quo[31:0]) * LO_PROD_W'(USEC_PER_SEC);
         m0_whole_hi_ff  <= whole_hi_in;
         m0_tick_prod_ff <= div1_out.side;
      end
   end

   // scale stage 1: whole product modulo 2^64, pick second dividend
   logic              m1_valid_ff;
   logic [WORD_W-1:0] m1_whole_prod_ff;
   logic [WORD_W-1:0] m1_dividend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (advance) begin
         m1_valid_ff <= m0_valid_ff;
      end
      if (advance) begin
         // tick path has no whole-units term
         m1_whole_prod_ff <= cycle_mode
                           ? WORD_W'(m0_whole_lo_ff) + {m0_whole_hi_ff, 32'd0} : '0;
         m1_dividend_ff   <= cycle_mode ? WORD_W'(m0_part_prod_ff) : m0_tick_prod_ff;
      end
   end

   // second divider: fraction or tick product over its divisor
   stage_type div2_in;
   stage_type div2_out;

   assign div2_in = '{valid: m1_valid_ff,
                      quo:   m1_dividend_ff,
                      rem:   '0,
                      side:  m1_whole_prod_ff};

   cyc2us_div_chain u_div2 (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .divisor   (div2_divisor),
      .chain_in  (div2_in),
      .chain_out (div2_out)
   );

   // output register
   logic [WORD_W-1:0] time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= div2_out.valid;
      end
      if (advance) begin
         time_ff <= div2_out.side + div2_out.quo;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_time_us = time_ff;

   // checks
   a_rem_below_freq : assert property (@(posedge clock) disable iff (reset)
      (div1_out.valid && cycle_mode) |-> (div1_out.rem < freq_ff))
      else $error("first divider remainder not below frequency");

   a_rem_below_div2 : assert property (@(posedge clock) disable iff (reset)
      div2_out.valid |-> (div2_out.rem < div2_divisor))
      else $error("second divider remainder not below divisor");

   a_beat_enters : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s0_valid_ff)
      else $error("accepted beat lost at entry stage");

   a_divisor_nonzero : assert property (@(posedge clock) disable iff (reset)
      m1_valid_ff |-> (div2_divisor != '0))
      else $error("second divider divisor is zero");

endmodule
